### rtl/nsfp_pkg.sv
package nsfp_pkg;

	// Default and fixed widths of the request and result fields.
	localparam int COUNT_BITS_DEF = 32;
	localparam int LARGER_BITS    = 32;
	localparam int SMALLER_BITS   = 16;

	// Width of the microprogram step counter.
	localparam int PC_BITS = 3;

	// Datapath operations selected by the control word.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_SQRT,
		OP_SETC,
		OP_DINIT,
		OP_DIV,
		OP_DEC,
		OP_DONE
	} op_t;

	// Jump conditions evaluated by the sequencer.
	typedef enum logic [1:0] {
		J_NEXT,
		J_LOOP,
		J_FOUND,
		J_ALWAYS
	} jump_t;

	// One control word of the microprogram.
	typedef struct packed {
		op_t                op;
		jump_t              jump;
		logic [PC_BITS-1:0] target;
		logic               last;
	} ucode_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		op_t  op;
	} ctrl_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic cnt_zero;
		logic found;
	} status_t;

	// Step addresses of the microprogram.
	localparam logic [PC_BITS-1:0] PC_SQRT  = 3'd0;
	localparam logic [PC_BITS-1:0] PC_SETC  = 3'd1;
	localparam logic [PC_BITS-1:0] PC_DINIT = 3'd2;
	localparam logic [PC_BITS-1:0] PC_DIV   = 3'd3;
	localparam logic [PC_BITS-1:0] PC_TEST  = 3'd4;
	localparam logic [PC_BITS-1:0] PC_DEC   = 3'd5;
	localparam logic [PC_BITS-1:0] PC_DONE  = 3'd6;

	// The microprogram: square root, then trial division stepping the candidate down.
	function automatic ucode_t ucode(input logic [PC_BITS-1:0] pc);
		ucode_t w;
		unique case (pc)
			PC_SQRT:  w = '{op: OP_SQRT,  jump: J_LOOP,   target: PC_SQRT,  last: 1'b0};
			PC_SETC:  w = '{op: OP_SETC,  jump: J_NEXT,   target: PC_SQRT,  last: 1'b0};
			PC_DINIT: w = '{op: OP_DINIT, jump: J_NEXT,   target: PC_SQRT,  last: 1'b0};
			PC_DIV:   w = '{op: OP_DIV,   jump: J_LOOP,   target: PC_DIV,   last: 1'b0};
			PC_TEST:  w = '{op: OP_NOP,   jump: J_FOUND,  target: PC_DONE,  last: 1'b0};
			PC_DEC:   w = '{op: OP_DEC,   jump: J_ALWAYS, target: PC_DINIT, last: 1'b0};
			PC_DONE:  w = '{op: OP_DONE,  jump: J_NEXT,   target: PC_SQRT,  last: 1'b1};
			default:  w = '{op: OP_NOP,   jump: J_NEXT,   target: PC_SQRT,  last: 1'b1};
		endcase
		return w;
	endfunction

endpackage

### rtl/nsfp_seq.sv
module nsfp_seq
	import nsfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output ctrl_t   ctrl,
	output logic    busy
);

	logic [PC_BITS-1:0] pc_q;
	logic               busy_q;
	logic [PC_BITS-1:0] pc_next;
	ucode_t             uw;

	// Fetch the control word of the current step.
	assign uw = ucode(pc_q);

	// Next step address from the jump condition.
	always_comb begin
		unique case (uw.jump)
			J_NEXT:   pc_next = pc_q + PC_BITS'(1);
			J_LOOP:   pc_next = status.cnt_zero ? pc_q + PC_BITS'(1) : uw.target;
			J_FOUND:  pc_next = status.found ? uw.target : pc_q + PC_BITS'(1);
			J_ALWAYS: pc_next = uw.target;
			default:  pc_next = PC_SQRT;
		endcase
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PC_SQRT;
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			if (start) begin
				pc_q   <= PC_SQRT;
				busy_q <= 1'b1;
			end
		end else begin
			pc_q <= pc_next;
			if (uw.last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Load a request while idle; drive datapath operations only while a request is in progress.
	assign ctrl.load = start & ~busy_q;
	assign ctrl.op   = busy_q ? uw.op : OP_NOP;
	assign busy      = busy_q;

endmodule

### rtl/nsfp_dp.sv
module nsfp_dp
	import nsfp_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_t                   ctrl,
	input  logic [COUNT_BITS-1:0]   count,
	output status_t                 status,
	output logic                    done,
	output logic [LARGER_BITS-1:0]  larger_factor,
	output logic [SMALLER_BITS-1:0] smaller_factor
);

	localparam int CAND_BITS = (COUNT_BITS + 1) / 2;
	localparam int SQ_STEPS  = (COUNT_BITS + 1) / 2;
	localparam int CNT_W     = $clog2(COUNT_BITS);

	logic [COUNT_BITS-1:0]   n_q;
	logic [COUNT_BITS-1:0]   rad_q;
	logic [COUNT_BITS-1:0]   root_q;
	logic [COUNT_BITS-1:0]   quo_q;
	logic [CAND_BITS:0]      rem_q;
	logic [CAND_BITS-1:0]    cand_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic [LARGER_BITS-1:0]  larger_q;
	logic [SMALLER_BITS-1:0] smaller_q;

	logic [COUNT_BITS-1:0]   sq_bit;
	logic [COUNT_BITS-1:0]   sq_trial;
	logic                    sq_take;
	logic [CAND_BITS:0]      div_shift;
	logic [CAND_BITS:0]      div_diff;
	logic                    div_take;
	logic [CAND_BITS-1:0]    root_cand;

	// One step of the bitwise square root: test root plus the current bit.
	assign sq_bit   = COUNT_BITS'(1) << {cnt_q, 1'b0};
	assign sq_trial = root_q + sq_bit;
	assign sq_take  = rad_q >= sq_trial;

	// One step of restoring division: shift in the next dividend bit.
	assign div_shift = {rem_q[CAND_BITS-1:0], quo_q[COUNT_BITS-1]};
	assign div_diff  = div_shift - {1'b0, cand_q};
	assign div_take  = div_shift >= {1'b0, cand_q};

	// The first candidate is the root, but never below one.
	assign root_cand = (root_q[CAND_BITS-1:0] == '0) ? CAND_BITS'(1)
		: root_q[CAND_BITS-1:0];

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			n_q    <= count;
			rad_q  <= count;
			root_q <= '0;
			cnt_q  <= CNT_W'(SQ_STEPS - 1);
		end else begin
			unique case (ctrl.op)
				OP_SQRT: begin
					if (sq_take) begin
						rad_q  <= rad_q - sq_trial;
						root_q <= (root_q >> 1) + sq_bit;
					end else begin
						root_q <= root_q >> 1;
					end
					cnt_q <= cnt_q - CNT_W'(1);
				end
				OP_SETC: begin
					cand_q <= root_cand;
				end
				OP_DINIT: begin
					rem_q <= '0;
					quo_q <= n_q;
					cnt_q <= CNT_W'(COUNT_BITS - 1);
				end
				OP_DIV: begin
					rem_q <= div_take ? div_diff : div_shift;
					quo_q <= {quo_q[COUNT_BITS-2:0], div_take};
					cnt_q <= cnt_q - CNT_W'(1);
				end
				OP_DEC: begin
					cand_q <= cand_q - CAND_BITS'(1);
				end
				OP_DONE: begin
					larger_q  <= LARGER_BITS'(quo_q);
					smaller_q <= SMALLER_BITS'(cand_q);
				end
				default: begin
				end
			endcase
		end
	end

	// Result strobe, high for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.op == OP_DONE);
		end
	end

	// Status for the sequencer's jumps.
	assign status.cnt_zero = (cnt_q == '0);
	assign status.found    = (rem_q == '0) || (cand_q == CAND_BITS'(1));

	assign done           = done_q;
	assign larger_factor  = larger_q;
	assign smaller_factor = smaller_q;

endmodule

### rtl/nearest_square_factor_pair.sv
// Channel   Ports                              Handshake
// request   count                              taken when start is high and busy is low
// result    larger_factor, smaller_factor      valid for one cycle while done is high
//
// A request tries candidates from the root downward; for each one the bit-serial divider
// produces one quotient bit a cycle.
// Reset clears the sequencer and the result strobe; the datapath registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
// A new request may be taken in the cycle that its predecessor's result is shown.
module nearest_square_factor_pair
	import nsfp_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [COUNT_BITS-1:0]   count,
	output logic                    done,
	output logic [LARGER_BITS-1:0]  larger_factor,
	output logic [SMALLER_BITS-1:0] smaller_factor
);

	ctrl_t   ctrl;
	status_t status;

	// Microprogram sequencer.
	nsfp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Square root and division datapath.
	nsfp_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.count          (count),
		.status         (status),
		.done           (done),
		.larger_factor  (larger_factor),
		.smaller_factor (smaller_factor)
	);

`ifndef ASSERT_OFF
	// A result only follows a cycle in which a request was in progress.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	// The sequencer is free again when the result is shown.
	a_idle_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still high with the result strobe");

	// A taken request makes the block busy.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but block not busy");

	// The smaller factor is never zero.
	a_nonzero_factor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (smaller_factor != '0))
		else $error("zero smaller factor");
`endif

endmodule
